>>> rtl/assert_macros.svh
// Assertion helper macros for the rate limiter RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

>>> rtl/psrl_pkg.sv
// ----------------------------------------------------------------------------
// psrl_pkg
// Types and constants for the per-source sliding-window rate limiter.
// ----------------------------------------------------------------------------
package psrl_pkg;

  localparam int unsigned TableEntriesDef = 1024;
  localparam int unsigned LogSlotsDef     = 16;
  localparam int unsigned SlotW           = 10;
  localparam int unsigned CountW          = 5;

  localparam logic [4:0] LimitReset  = 5'd10;
  localparam logic [7:0] WindowReset = 8'd1;

  localparam logic [1:0] VerdictKnown = 2'd0;
  localparam logic [1:0] VerdictNew   = 2'd1;
  localparam logic [1:0] VerdictOver  = 2'd2;
  localparam logic [1:0] VerdictFull  = 2'd3;

  localparam logic [0:0] RegLimit  = 1'd0;
  localparam logic [0:0] RegWindow = 1'd1;

  typedef struct packed {
    logic [31:0] source_addr;
    logic [31:0] now_seconds;
  } req_t;

  typedef struct packed {
    logic              allowed;
    logic [1:0]        verdict;
    logic [SlotW-1:0]  entry_slot;
    logic [CountW-1:0] recent_count;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_CNT_RD,
    ST_CNT_WAIT,
    ST_LOG_RD,
    ST_LOG_CMP,
    ST_DECIDE,
    ST_OUT
  } state_t;

  function automatic logic still_recent(input logic [31:0] now,
                                        input logic [31:0] stamp,
                                        input logic [7:0]  window);
    logic [31:0] age;
    age = now - stamp;
    return age[31] || (age < {24'd0, window});
  endfunction

endpackage

>>> rtl/per_source_sliding_window_rate_limiter.sv
// Search reads one key per visited entry, then the log of a hit is compacted one
// stored stamp at a time, so the time taken grows with the entries in use and
// with the stored stamps of the hit. One item at a time.
// Throughput is set by the key memory scan and the log memory read port.
// Reset clears only control state, entries_used and the limit and window registers; memories need no clearing.
// ----------------------------------------------------------------------------
// per_source_sliding_window_rate_limiter
// Top level: source table search, log compaction, verdict.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module per_source_sliding_window_rate_limiter
  import psrl_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDef,
  parameter int unsigned LOG_SLOTS     = LogSlotsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  req_t        in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output rsp_t        out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned IdxW  = $clog2(TABLE_ENTRIES);
  localparam int unsigned UsedW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned JW    = (LOG_SLOTS > 1) ? $clog2(LOG_SLOTS) : 1;
  localparam int unsigned NW    = $clog2(LOG_SLOTS + 1);
  localparam int unsigned LogD  = TABLE_ENTRIES * LOG_SLOTS;
  localparam int unsigned LogAW = $clog2(LogD);

  logic [31:0] key_mem [TABLE_ENTRIES];
  logic [NW-1:0] cnt_mem [TABLE_ENTRIES];
  logic [31:0] log_mem [LogD];

  logic [4:0] limit_r;
  logic [7:0] window_r;
  logic [UsedW-1:0] used_r, used_nxt;
  state_t state_r, state_nxt;
  req_t req_r, req_nxt;
  logic [UsedW-1:0] idx_r, idx_nxt;
  logic [NW-1:0] n_r, n_nxt, rd_j_r, rd_j_nxt, kept_r, kept_nxt;
  rsp_t rsp_r, rsp_nxt;

  logic [31:0] key_q, log_q;
  logic [NW-1:0] cnt_q;

  logic key_we, cnt_we, log_we;
  logic [IdxW-1:0] key_wa, cnt_wa;
  logic [31:0] key_wd, log_wd;
  logic [NW-1:0] cnt_wd;
  logic [LogAW-1:0] log_wa, log_ra;
  logic [NW-1:0] lim_eff;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= LimitReset;
      window_r <= WindowReset;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == RegLimit && cfg_paddr[1:0] == 2'd0)
        limit_r <= cfg_pwdata[4:0];
      else if (cfg_paddr[2] == RegWindow && cfg_paddr[1:0] == 2'd0)
        window_r <= cfg_pwdata[7:0];
    end
  end

  always_comb begin
    cfg_prdata = 32'd0;
    if (cfg_paddr[2] == RegLimit) cfg_prdata = {27'd0, limit_r};
    else cfg_prdata = {24'd0, window_r};
  end

  always_comb begin
    if (limit_r == 5'd0) lim_eff = NW'(1);
    else if (32'(limit_r) > LOG_SLOTS) lim_eff = NW'(LOG_SLOTS);
    else lim_eff = NW'(limit_r);
  end

  // memories
  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_wa] <= key_wd;
    key_q <= key_mem[idx_r[IdxW-1:0]];
  end
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    cnt_q <= cnt_mem[idx_r[IdxW-1:0]];
  end
  always_ff @(posedge clk) begin
    if (log_we) log_mem[log_wa] <= log_wd;
    log_q <= log_mem[log_ra];
  end

  assign log_ra = LogAW'(32'(idx_r) * LOG_SLOTS + 32'(rd_j_r[JW-1:0]));

  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_data = rsp_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_SRCH_RD;
      ST_SRCH_RD:  state_nxt = (32'(idx_r) < 32'(used_r)) ? ST_SRCH_CMP : ST_DECIDE;
      ST_SRCH_CMP: state_nxt = (key_q == req_r.source_addr) ? ST_CNT_RD : ST_SRCH_RD;
      ST_CNT_RD:   state_nxt = ST_CNT_WAIT;
      ST_CNT_WAIT: state_nxt = ST_LOG_RD;
      ST_LOG_RD:   state_nxt = (rd_j_r < n_r) ? ST_LOG_CMP : ST_DECIDE;
      ST_LOG_CMP:  state_nxt = ST_LOG_RD;
      ST_DECIDE:   state_nxt = ST_OUT;
      ST_OUT:      if (out_ready) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    req_nxt = req_r; idx_nxt = idx_r; n_nxt = n_r; rd_j_nxt = rd_j_r;
    kept_nxt = kept_r; rsp_nxt = rsp_r; used_nxt = used_r;
    key_we = 1'b0; cnt_we = 1'b0; log_we = 1'b0;
    key_wa = idx_r[IdxW-1:0]; cnt_wa = idx_r[IdxW-1:0]; key_wd = req_r.source_addr;
    cnt_wd = kept_r; log_wd = req_r.now_seconds;
    log_wa = LogAW'(32'(idx_r) * LOG_SLOTS + 32'(kept_r[JW-1:0]));
    case (state_r)
      ST_IDLE: begin
        req_nxt = in_data; idx_nxt = '0; rd_j_nxt = '0; kept_nxt = '0;
        n_nxt = '0;
      end
      ST_SRCH_CMP: begin
        if (key_q != req_r.source_addr) idx_nxt = idx_r + 1'b1;
      end
      ST_CNT_WAIT: begin
        n_nxt = (32'(cnt_q) > LOG_SLOTS) ? NW'(LOG_SLOTS) : cnt_q;
      end
      ST_LOG_CMP: begin
        rd_j_nxt = rd_j_r + 1'b1;
        if (still_recent(req_r.now_seconds, log_q, window_r)) begin
          log_we = 1'b1; log_wd = log_q;
          kept_nxt = kept_r + 1'b1;
        end
      end
      ST_DECIDE: begin
        if (32'(idx_r) < 32'(used_r)) begin
          // hit path
          if (kept_r >= lim_eff) begin
            cnt_we = 1'b1; cnt_wd = kept_r;
            rsp_nxt = '{1'b0, VerdictOver, SlotW'(idx_r), CountW'(kept_r)};
          end else begin
            log_we = 1'b1; cnt_we = 1'b1; cnt_wd = kept_r + 1'b1;
            rsp_nxt = '{1'b1, VerdictKnown, SlotW'(idx_r), CountW'(kept_r + 1'b1)};
          end
        end else if (32'(used_r) < TABLE_ENTRIES) begin
          key_we = 1'b1; cnt_we = 1'b1; cnt_wd = NW'(1); log_we = 1'b1;
          log_wa = LogAW'(32'(idx_r) * LOG_SLOTS);
          used_nxt = used_r + 1'b1;
          rsp_nxt = '{1'b1, VerdictNew, SlotW'(idx_r), CountW'(1)};
        end else begin
          rsp_nxt = '{1'b0, VerdictFull, SlotW'(0), CountW'(0)};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      used_r  <= '0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt; idx_r <= idx_nxt; n_r <= n_nxt;
    rd_j_r <= rd_j_nxt; kept_r <= kept_nxt; rsp_r <= rsp_nxt;
  end

  `ASSERT_IMPLY(a_used_bound, clk, rst_n, 1'b1, 32'(used_r) <= TABLE_ENTRIES, "used overflow")
  `ASSERT_IMPLY(a_kept_bound, clk, rst_n, 1'b1, kept_r <= n_r, "kept exceeds read count")
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped")

endmodule
